/* src/cpe_pkg.sv */
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and saturating fixed-point helpers of the polynomial engine.
// ----------------------------------------------------------------------------
package cpe_pkg;

   localparam logic [3:0] CMD_LOAD   = 4'd0;
   localparam logic [3:0] CMD_EVAL   = 4'd1;
   localparam logic [3:0] CMD_EVALD  = 4'd2;
   localparam logic [3:0] CMD_TPLUS  = 4'd3;
   localparam logic [3:0] CMD_TMINUS = 4'd4;
   localparam logic [3:0] CMD_SCALE  = 4'd5;
   localparam logic [3:0] CMD_DIFF   = 4'd6;
   localparam logic [3:0] CMD_ADD    = 4'd7;
   localparam logic [3:0] CMD_READ   = 4'd8;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_INDEX    = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;
   localparam logic [1:0] STAT_SAT      = 2'd3;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } cval_type;

   typedef struct packed {
      cval_type v;
      logic     sat;
   } csat_type;

   function automatic logic signed [31:0] clip32(input logic signed [64:0] v);
      if (v > 65'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic over32(input logic signed [64:0] v);
      return (v > 65'sd2147483647) || (v < -65'sd2147483648);
   endfunction

   function automatic csat_type sat_pair(input logic signed [64:0] re,
                                         input logic signed [64:0] im);
      csat_type r;
      r.v.re = clip32(re);
      r.v.im = clip32(im);
      r.sat  = over32(re) | over32(im);
      return r;
   endfunction

   function automatic csat_type cadd(input cval_type a, input cval_type b);
      return sat_pair(65'(a.re) + 65'(b.re), 65'(a.im) + 65'(b.im));
   endfunction

   // multiply by a small unsigned integer
   function automatic csat_type cint(input cval_type a, input logic [7:0] k);
      logic signed [8:0] ks;
      ks = $signed({1'b0, k});
      return sat_pair(65'(a.re * ks), 65'(a.im * ks));
   endfunction

   // exact 33-bit sum or difference, halved toward minus infinity
   function automatic cval_type chalf(input cval_type a, input cval_type b,
                                      input logic minus);
      cval_type r;
      logic signed [32:0] sr;
      logic signed [32:0] si;
      sr = minus ? 33'(a.re) - 33'(b.re) : 33'(a.re) + 33'(b.re);
      si = minus ? 33'(a.im) - 33'(b.im) : 33'(a.im) + 33'(b.im);
      r.re = sr[32:1];
      r.im = si[32:1];
      return r;
   endfunction

endpackage

/* src/cpe_if.sv */
// ----------------------------------------------------------------------------
// cpe_if
// Request and response channels of the polynomial engine.
// ----------------------------------------------------------------------------
interface cpe_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         command;
   logic [3:0]         index;
   logic signed [31:0] operand_re;
   logic signed [31:0] operand_im;
   modport source(output valid, command, index, operand_re, operand_im, input ready);
   modport sink(input valid, command, index, operand_re, operand_im, output ready);
endinterface

interface cpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_re;
   logic signed [31:0] result_im;
   logic [1:0]         status;
   logic [4:0]         term_count;
   modport source(output valid, result_re, result_im, status, term_count, input ready);
   modport sink(input valid, result_re, result_im, status, term_count, output ready);
endinterface

/* src/complex_polynomial_engine.sv */
// ----------------------------------------------------------------------------
// complex_polynomial_engine
// Complex polynomial store with load, add, read, evaluate, shift-add maps,
// scaling and differentiation in saturating fixed point.
// ----------------------------------------------------------------------------
// One word is taken at a time. Load and unknown commands pass dispatch and
// response, read and add a data state too; the shift-add maps and
// differentiation walk the coefficient memory through loop and data states,
// scale also through the two-stage complex multiplier, which evaluation
// shares between the term product and the power update. A finished result
// waits in the output register while the next word is accepted. A flag per
// entry marks it as written since it last fell outside the length; entries
// without it read as zero, so the memory needs no clearing pass after reset.
module complex_polynomial_engine import cpe_pkg::*; #(
   parameter int MAX_TERMS = 16,
   parameter int FRAC_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   cpe_req_if.sink  req,
   cpe_rsp_if.source rsp
);

   localparam int LW = $clog2(MAX_TERMS + 1);
   localparam int AW = $clog2(MAX_TERMS);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DISP = 4'd1;
   localparam logic [3:0] ST_LOOP = 4'd2;
   localparam logic [3:0] ST_DATA = 4'd3;
   localparam logic [3:0] ST_M1   = 4'd4;
   localparam logic [3:0] ST_M2   = 4'd5;
   localparam logic [3:0] ST_USE  = 4'd6;
   localparam logic [3:0] ST_RESP = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] i_ff, i_in;
   logic [3:0]    cmd_ff;
   logic [3:0]    idx_ff;
   cval_type      op_ff;
   cval_type      acc_ff, acc_in;
   cval_type      pw_ff, pw_in;
   cval_type      prev_ff, prev_in;
   cval_type      res_ff, res_in;
   cval_type      ma_ff, ma_in, mb_ff, mb_in;
   logic          phase_ff, phase_in;
   logic          sat_ff, sat_in;
   logic [1:0]    st_ff, st_in;

   cval_type      mem [MAX_TERMS];
   logic [MAX_TERMS-1:0] vld_ff, vld_in;
   cval_type      rd_ff;
   logic          rd_ok_ff;
   logic          we;
   logic [AW-1:0] wa;
   cval_type      wd;

   csat_type      mp;
   csat_type      ci;
   csat_type      ca;
   csat_type      acc_sum;
   cval_type      c;
   logic          beyond;
   logic          deriv;
   logic          minus;
   logic          rsp_valid_ff;
   cval_type      rsp_res_ff;
   logic [1:0]    rsp_st_ff;
   logic [LW-1:0] rsp_len_ff;
   logic          rsp_load;

   cpe_cmul #(.FRAC_BITS(FRAC_BITS)) u_cmul (
      .clock (clock),
      .a     (ma_ff),
      .b     (mb_ff),
      .p     (mp)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff    <= mem[i_ff[AW-1:0]];
      rd_ok_ff <= vld_ff[i_ff[AW-1:0]] && (i_ff < len_ff);
   end

   // unwritten entries and entries at or past the length read as zero
   assign c       = rd_ok_ff ? rd_ff : '0;
   assign ci      = cint(c, 8'(i_ff));
   assign ca      = cadd(c, op_ff);
   assign acc_sum = cadd(acc_ff, mp.v);
   assign beyond  = 32'(idx_ff) >= MAX_TERMS;
   assign deriv   = cmd_ff == CMD_EVALD;
   assign minus   = cmd_ff == CMD_TMINUS;
   assign req.ready = state_ff == ST_IDLE;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      i_in     = i_ff;
      acc_in   = acc_ff;
      pw_in    = pw_ff;
      prev_in  = prev_ff;
      res_in   = res_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      phase_in = phase_ff;
      sat_in   = sat_ff;
      st_in    = st_ff;
      we       = 1'b0;
      wa       = i_ff[AW-1:0];
      wd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               acc_in   = '0;
               pw_in    = '{re: ONE, im: 32'sd0};
               res_in   = '0;
               sat_in   = 1'b0;
               st_in    = STAT_OK;
               phase_in = 1'b0;
               prev_in  = '{re: req.operand_re, im: req.operand_im};
               if (req.command == CMD_EVALD || req.command == CMD_DIFF) begin
                  i_in = LW'(1);
               end else if (req.command == CMD_ADD || req.command == CMD_READ) begin
                  i_in = LW'(req.index);
               end else begin
                  i_in = '0;
               end
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (cmd_ff)
               CMD_LOAD: begin
                  if (beyond) begin
                     st_in = STAT_INDEX;
                  end else begin
                     we     = 1'b1;
                     wa     = AW'(idx_ff);
                     wd     = op_ff;
                     len_in = LW'(idx_ff) + LW'(1);
                  end
                  state_in = ST_RESP;
               end
               CMD_ADD, CMD_READ: begin
                  if (beyond) begin
                     st_in    = STAT_INDEX;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_DATA;
                  end
               end
               CMD_TPLUS, CMD_TMINUS: begin
                  if (32'(len_ff) >= MAX_TERMS) begin
                     st_in    = STAT_OVERFLOW;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_LOOP;
                  end
               end
               CMD_EVAL, CMD_EVALD, CMD_SCALE, CMD_DIFF: begin
                  state_in = ST_LOOP;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_LOOP: begin
            // the read of entry i is issued here and lands in ST_DATA
            if ((cmd_ff == CMD_TPLUS || cmd_ff == CMD_TMINUS) ? i_ff <= len_ff
                                                             : i_ff < len_ff) begin
               state_in = ST_DATA;
            end else begin
               state_in = ST_RESP;
               case (cmd_ff)
                  CMD_EVAL, CMD_EVALD: begin
                     res_in = acc_ff;
                  end
                  CMD_TPLUS, CMD_TMINUS: begin
                     len_in = len_ff + LW'(1);
                  end
                  CMD_DIFF: begin
                     if (len_ff > LW'(1)) begin
                        len_in = len_ff - LW'(1);
                     end else begin
                        we = 1'b1;
                        wa = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DATA: begin
            case (cmd_ff)
               CMD_READ: begin
                  res_in   = c;
                  state_in = ST_RESP;
               end
               CMD_ADD: begin
                  we     = 1'b1;
                  wd     = ca.v;
                  sat_in = sat_ff | ca.sat;
                  if (len_ff < i_ff + LW'(1)) begin
                     len_in = i_ff + LW'(1);
                  end
                  state_in = ST_RESP;
               end
               CMD_TPLUS, CMD_TMINUS: begin
                  we       = 1'b1;
                  wd       = chalf(prev_ff, c, minus);
                  prev_in  = c;
                  i_in     = i_ff + LW'(1);
                  state_in = ST_LOOP;
               end
               CMD_DIFF: begin
                  we       = 1'b1;
                  wa       = AW'(i_ff - LW'(1));
                  wd       = ci.v;
                  sat_in   = sat_ff | ci.sat;
                  i_in     = i_ff + LW'(1);
                  state_in = ST_LOOP;
               end
               CMD_SCALE: begin
                  ma_in    = c;
                  mb_in    = op_ff;
                  state_in = ST_M1;
               end
               default: begin
                  // evaluation: term times current power
                  if (deriv) begin
                     ma_in  = ci.v;
                     sat_in = sat_ff | ci.sat;
                  end else begin
                     ma_in = c;
                  end
                  mb_in    = pw_ff;
                  phase_in = 1'b0;
                  state_in = ST_M1;
               end
            endcase
         end
         ST_M1: begin
            state_in = ST_M2;
         end
         ST_M2: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            sat_in = sat_ff | mp.sat;
            if (cmd_ff == CMD_SCALE) begin
               we       = 1'b1;
               wd       = mp.v;
               i_in     = i_ff + LW'(1);
               state_in = ST_LOOP;
            end else if (phase_ff) begin
               pw_in    = mp.v;
               i_in     = i_ff + LW'(1);
               state_in = ST_LOOP;
            end else begin
               acc_in = acc_sum.v;
               sat_in = sat_ff | mp.sat | acc_sum.sat;
               // advance the power only while terms remain
               if ({1'b0, i_ff} + (LW + 1)'(1) < {1'b0, len_ff}) begin
                  ma_in    = pw_ff;
                  mb_in    = op_ff;
                  phase_in = 1'b1;
                  state_in = ST_M1;
               end else begin
                  i_in     = i_ff + LW'(1);
                  state_in = ST_LOOP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[wa] = 1'b1;
      end
      // drop the flags of entries that fall outside a shorter length
      for (int j = 0; j < MAX_TERMS; j++) begin
         if (len_in < len_ff && j >= int'(len_in)) begin
            vld_in[j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LW'(1);
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         vld_ff   <= vld_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cmd_ff <= req.command;
         idx_ff <= req.index;
         op_ff  <= '{re: req.operand_re, im: req.operand_im};
      end
      i_ff     <= i_in;
      acc_ff   <= acc_in;
      pw_ff    <= pw_in;
      prev_ff  <= prev_in;
      res_ff   <= res_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      phase_ff <= phase_in;
      sat_ff   <= sat_in;
      st_ff    <= st_in;
      if (rsp_load) begin
         rsp_res_ff <= res_ff;
         rsp_st_ff  <= (st_ff == STAT_OK && sat_ff) ? STAT_SAT : st_ff;
         rsp_len_ff <= len_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.result_re  = rsp_res_ff.re;
   assign rsp.result_im  = rsp_res_ff.im;
   assign rsp.status     = rsp_st_ff;
   assign rsp.term_count = 5'(rsp_len_ff);

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff >= LW'(1) && 32'(len_ff) <= MAX_TERMS)
      else $error("term length out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == ST_DISP)
      else $error("accepted word not dispatched");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp.valid && state_ff == ST_IDLE)
      else $error("result not presented");

endmodule

/* src/cpe_cmul.sv */
// ----------------------------------------------------------------------------
// cpe_cmul
// Two-stage complex multiplier: exact products, then floor shift and clip.
// ----------------------------------------------------------------------------
module cpe_cmul import cpe_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  cval_type a,
   input  cval_type b,
   output csat_type p
);

   logic signed [63:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [64:0] re_in, im_in;
   csat_type           p_ff;

   always_ff @(posedge clock) begin
      rr_ff <= a.re * b.re;
      ii_ff <= a.im * b.im;
      ri_ff <= a.re * b.im;
      ir_ff <= a.im * b.re;
   end

   // arithmetic shift rounds toward minus infinity
   assign re_in = 65'(rr_ff >>> FRAC_BITS) - 65'(ii_ff >>> FRAC_BITS);
   assign im_in = 65'(ri_ff >>> FRAC_BITS) + 65'(ir_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      p_ff <= sat_pair(re_in, im_in);
   end

   assign p = p_ff;

endmodule
